[rtl/kst_pkg.sv]
// kst_pkg: shared types, widths and codes of the keyed secret table
// no dependencies; used by every other file of the block except kst_ram

package kst_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;

  localparam int unsigned ID_W   = 64;
  localparam int unsigned NUM_W  = 31;
  localparam int unsigned STAT_W = 8;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned ACT_W  = 5;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CODE_W = 2;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [CODE_W-1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2
  } res_code_e;

  // one stored key record, as held in a table entry
  typedef struct packed {
    logic [ID_W-1:0]   client_id;
    logic [ID_W-1:0]   server_id;
    logic [NUM_W-1:0]  key_number;
    logic [STAT_W-1:0] record_status;
    logic [KEY_W-1:0]  key_word;
  } rec_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic load;
    logic scan_rd;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

[rtl/kst_req_if.sv]
// kst_req_if: request channel of the keyed secret table (valid/ready plus payload)
// depends on kst_pkg for field widths

interface kst_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [kst_pkg::ID_W-1:0]    client_id;
  logic [kst_pkg::ID_W-1:0]    server_id;
  logic [kst_pkg::NUM_W-1:0]   key_number;
  logic [kst_pkg::STAT_W-1:0]  record_status;
  logic [kst_pkg::KEY_W-1:0]   key_word;

  modport source (
    output valid, op, client_id, server_id, key_number, record_status, key_word,
    input  ready
  );

  modport sink (
    input  valid, op, client_id, server_id, key_number, record_status, key_word,
    output ready
  );
endinterface

[rtl/kst_rsp_if.sv]
// kst_rsp_if: result channel of the keyed secret table (valid/ready plus payload)
// depends on kst_pkg for field widths

interface kst_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [kst_pkg::CODE_W-1:0]  result_code;
  logic [kst_pkg::SLOT_W-1:0]  slot_used;
  logic [kst_pkg::STAT_W-1:0]  found_status;
  logic [kst_pkg::NUM_W-1:0]   found_key_number;
  logic [kst_pkg::KEY_W-1:0]   found_key_word;

  modport source (
    output valid, result_code, slot_used, found_status, found_key_number, found_key_word,
    input  ready
  );

  modport sink (
    input  valid, result_code, slot_used, found_status, found_key_number, found_key_word,
    output ready
  );
endinterface

[rtl/kst_ram.sv]
// kst_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module kst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kst_datapath.sv]
// kst_datapath: request and result registers, table ram, scan counter and compare
// depends on kst_pkg and kst_ram; steered by kst_ctrl through cmd_t / sts_t

module kst_datapath #(
  parameter int unsigned TABLE_DEPTH = kst_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kst_pkg::ACT_W-1:0]     cfg_wdata_i,
  input  kst_pkg::cmd_t                 cmd_i,
  output kst_pkg::sts_t                 sts_o,
  input  logic                          op_i,
  input  logic [kst_pkg::ID_W-1:0]      client_id_i,
  input  logic [kst_pkg::ID_W-1:0]      server_id_i,
  input  logic [kst_pkg::NUM_W-1:0]     key_number_i,
  input  logic [kst_pkg::STAT_W-1:0]    record_status_i,
  input  logic [kst_pkg::KEY_W-1:0]     key_word_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [kst_pkg::CODE_W-1:0]    result_code_o,
  output logic [kst_pkg::SLOT_W-1:0]    slot_used_o,
  output logic [kst_pkg::STAT_W-1:0]    found_status_o,
  output logic [kst_pkg::NUM_W-1:0]     found_key_number_o,
  output logic [kst_pkg::KEY_W-1:0]     found_key_word_o
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > kst_pkg::ACT_W) ? CNT_W : kst_pkg::ACT_W;
  localparam int unsigned REC_W = $bits(kst_pkg::rec_t);
  localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  logic [kst_pkg::ACT_W-1:0] active_q;
  logic                      op_q;
  kst_pkg::rec_t             req_q;
  logic [CNT_W-1:0]          span_q, span_d;
  logic [CNT_W-1:0]          addr_q, addr_d;
  logic                      cmp_valid_q;
  logic [IDX_W-1:0]          cmp_idx_q;
  logic                      match_found_q, free_found_q;
  logic [IDX_W-1:0]          match_idx_q, free_idx_q;
  kst_pkg::rec_t             match_rec_q;

  logic                      out_valid_q;
  logic [kst_pkg::CODE_W-1:0] code_q, code_d;
  logic [kst_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [kst_pkg::STAT_W-1:0] fstat_q, fstat_d;
  logic [kst_pkg::NUM_W-1:0]  fnum_q, fnum_d;
  logic [kst_pkg::KEY_W-1:0]  fkey_q, fkey_d;

  logic [REC_W-1:0]          rd_data;
  kst_pkg::rec_t             rd_rec;
  logic                      hit, free_hit;
  logic                      tgt_found;
  logic [IDX_W-1:0]          tgt_idx;
  logic [IDX_W-1:0]          slot_idx;
  logic [IDX_W+kst_pkg::SLOT_W-1:0] slot_ext;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_waddr;
  logic [REC_W-1:0]          ram_wdata;
  logic                      is_write;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= kst_pkg::ACTIVE_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // entries searched: active count capped at the table depth
  always_comb begin
    if (CMP_W'(active_q) > CMP_W'(TABLE_DEPTH)) begin
      span_d = DEPTH_CNT;
    end else begin
      span_d = CNT_W'(active_q);
    end
  end

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.load) begin
      addr_d = '0;
    end else if (cmd_i.clr_wr) begin
      addr_d = (addr_q == LAST_IDX) ? '0 : addr_q + CNT_W'(1);
    end else if (cmd_i.scan_rd) begin
      addr_d = addr_q + CNT_W'(1);
    end
  end

  assign rd_rec   = kst_pkg::rec_t'(rd_data);
  assign hit      = cmp_valid_q && (rd_rec.client_id == req_q.client_id) &&
                    (rd_rec.server_id == req_q.server_id);
  assign free_hit = cmp_valid_q && (rd_data == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q        <= '0;
      cmp_valid_q   <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      addr_q      <= addr_d;
      cmp_valid_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
      end else begin
        if (hit) begin
          match_found_q <= 1'b1;
        end
        if (free_hit) begin
          free_found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, first match and first free entry only
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      span_q <= span_d;
      req_q  <= '{client_id:     client_id_i,
                  server_id:     server_id_i,
                  key_number:    key_number_i,
                  record_status: record_status_i,
                  key_word:      key_word_i};
    end
    cmp_idx_q <= addr_q[IDX_W-1:0];
    if (hit && !match_found_q) begin
      match_idx_q <= cmp_idx_q;
      match_rec_q <= rd_rec;
    end
    if (free_hit && !free_found_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (cmd_i.finish) begin
      code_q  <= code_d;
      slot_q  <= slot_d;
      fstat_q <= fstat_d;
      fnum_q  <= fnum_d;
      fkey_q  <= fkey_d;
    end
  end

  assign is_write  = (op_q == kst_pkg::OP_WRITE);
  assign tgt_found = match_found_q || free_found_q;
  assign tgt_idx   = match_found_q ? match_idx_q : free_idx_q;
  assign slot_idx  = is_write ? tgt_idx : match_idx_q;
  assign slot_ext  = {{kst_pkg::SLOT_W{1'b0}}, slot_idx};

  always_comb begin
    code_d  = kst_pkg::RES_OK;
    slot_d  = slot_ext[kst_pkg::SLOT_W-1:0];
    fstat_d = '0;
    fnum_d  = '0;
    fkey_d  = '0;
    if (is_write) begin
      if (!tgt_found) begin
        code_d = kst_pkg::RES_FULL;
        slot_d = '0;
      end
    end else if (!match_found_q) begin
      code_d = kst_pkg::RES_NOT_FOUND;
      slot_d = '0;
    end else begin
      fstat_d = match_rec_q.record_status;
      fnum_d  = match_rec_q.key_number;
      fkey_d  = match_rec_q.key_word;
    end
  end

  // clear sweep writes zeros; a finished write that found a slot stores the request record
  assign ram_we    = cmd_i.clr_wr || (cmd_i.finish && is_write && tgt_found);
  assign ram_waddr = cmd_i.clr_wr ? addr_q[IDX_W-1:0] : tgt_idx;
  assign ram_wdata = cmd_i.clr_wr ? '0 : REC_W'(req_q);

  kst_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (addr_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  assign sts_o.clr_last  = (addr_q == LAST_IDX);
  assign sts_o.scan_done = (addr_q == span_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign result_code_o      = code_q;
  assign slot_used_o        = slot_q;
  assign found_status_o     = fstat_q;
  assign found_key_number_o = fnum_q;
  assign found_key_word_o   = fkey_q;

endmodule

[rtl/kst_ctrl.sv]
// kst_ctrl: sequencer of the keyed secret table (clear sweep, accept, scan, finish)
// depends on kst_pkg; drives kst_datapath through cmd_t and reads sts_t

module kst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kst_pkg::sts_t sts_i,
  output kst_pkg::cmd_t cmd_o
);

  kst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kst_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kst_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = kst_pkg::ST_IDLE;
        end
      end
      kst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = kst_pkg::ST_SCAN;
        end
      end
      kst_pkg::ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = kst_pkg::ST_FINISH;
        end
      end
      kst_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = kst_pkg::ST_IDLE;
        end
      end
      default: state_d = kst_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      kst_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      kst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      kst_pkg::ST_SCAN: begin
        cmd_o.scan_rd = !sts_i.scan_done;
      end
      kst_pkg::ST_FINISH: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[rtl/keyed_secret_table.sv]
// keyed_secret_table: top level, key records looked up by client/server id pair
// depends on kst_pkg, kst_req_if, kst_rsp_if, kst_ctrl, kst_datapath (and kst_ram)
//
//  channel  direction  transfer when        payload
//  req      in         valid & ready        op, ids, key number, status, key word
//  rsp      out        valid & ready        result code, slot, found fields
//  cfg      in         cfg_we_i             active_entries (5 bits), no read-back
//
//  an item scans span = min(active_entries, TABLE_DEPTH) entries between its transfer
//  and its result; each entry is read once from the one-read-a-cycle table ram and
//  compared the cycle after
//  after reset a clearing pass writes zeros to all TABLE_DEPTH entries, one per
//  cycle, with req.ready low; configuration writes are taken during it
//  a new request is taken while the previous result still waits in the output register;
//  a stalled rsp only holds the finish step of the next item

module keyed_secret_table #(
  parameter int unsigned TABLE_DEPTH = kst_pkg::TABLE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [kst_pkg::ACT_W-1:0] cfg_wdata_i,
  kst_req_if.sink                   req,
  kst_rsp_if.source                 rsp
);

  kst_pkg::cmd_t cmd;
  kst_pkg::sts_t sts;

  // sequencer: clear sweep, accept, scan, finish
  kst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, compare logic and result register
  kst_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .op_i               (req.op),
    .client_id_i        (req.client_id),
    .server_id_i        (req.server_id),
    .key_number_i       (req.key_number),
    .record_status_i    (req.record_status),
    .key_word_i         (req.key_word),
    .out_ready_i        (rsp.ready),
    .out_valid_o        (rsp.valid),
    .result_code_o      (rsp.result_code),
    .slot_used_o        (rsp.slot_used),
    .found_status_o     (rsp.found_status),
    .found_key_number_o (rsp.found_key_number),
    .found_key_word_o   (rsp.found_key_word)
  );

endmodule
